// File: hw/rtl/rbfpid_pkg.sv
// Shared types, widths and constants of the RBF PID gain scheduler.
package rbfpid_pkg;

	localparam int ERR_W     = 24;
	localparam int CFG_W     = 24;
	localparam int WID_W     = 23;
	localparam int CFG_IDX_W = 3;
	localparam int GAIN_W    = 14;
	localparam int DIFF_W    = 25;
	localparam int D2_W      = 49;
	localparam int S2_W      = 46;
	localparam int REM_W     = 46;
	localparam int Q_W       = 20;
	localparam int FRAC_W    = 20;
	localparam int PHI_W     = 17;
	localparam int PROD_W    = PHI_W + GAIN_W;
	localparam int TOT_W     = 18;
	localparam int NUM_W     = 32;

	localparam int MAX_NEURONS         = 3;
	localparam int GAIN_COUNT          = 3;
	localparam int NEURON_COUNT_DEF    = 3;
	localparam int EXP_TABLE_DEPTH_DEF = 256;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_C  = 3'd5;

	localparam logic signed [CFG_W-1:0] CENTER_RST [MAX_NEURONS] = '{
		24'sd0, 24'sd5120, 24'sd25600
	};
	localparam logic [WID_W-1:0] WIDTH_RST [MAX_NEURONS] = '{
		23'd2560, 23'd5120, 23'd10240
	};

	// [neuron][gain], gains ordered p, i, d, Q2.12
	localparam logic [GAIN_W-1:0] WEIGHTS [MAX_NEURONS][GAIN_COUNT] = '{
		'{14'd8192, 14'd6144, 14'd2048},
		'{14'd6144, 14'd3686, 14'd1638},
		'{14'd4096, 14'd2048, 14'd1229}
	};
	localparam logic [GAIN_W-1:0] GAIN_MAX = 14'd8192;

	// one neuron after classification
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [4:0]       low5;
		logic [S2_W-1:0]  s2;
		logic             zero;
	} lane_t;

endpackage

// File: hw/rtl/rbf_pid_gain_scheduler.sv
// Throughput: one request per cycle unless gain_ready holds the output; the exponent
// divider (20 stages), the table interpolation and the normalizing divider
// (14 stages) are fully pipelined.
// A two-entry queue parts front and back so each side stalls on its own.
// Reset: asynchronous, active low; clears all valid bits and loads the
// default centers and widths. No clearing pass; the exp table is constant.
module rbf_pid_gain_scheduler #(
	parameter int NEURON_COUNT    = rbfpid_pkg::NEURON_COUNT_DEF,
	parameter int EXP_TABLE_DEPTH = rbfpid_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rbfpid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbfpid_pkg::CFG_W-1:0]        cfg_data,
	input  logic                                err_valid,
	output logic                                err_ready,
	input  logic signed [rbfpid_pkg::ERR_W-1:0] error_sample,
	output logic                                gain_valid,
	input  logic                                gain_ready,
	output logic [rbfpid_pkg::GAIN_W-1:0]       gain_p,
	output logic [rbfpid_pkg::GAIN_W-1:0]       gain_i,
	output logic [rbfpid_pkg::GAIN_W-1:0]       gain_d
);

	localparam int ITEM_W = $bits(rbfpid_pkg::lane_t) * NEURON_COUNT;

	logic                                 f_valid, f_ready;
	rbfpid_pkg::lane_t [NEURON_COUNT-1:0] f_item;
	logic                                 b_valid, b_ready;
	rbfpid_pkg::lane_t [NEURON_COUNT-1:0] b_item;

	rbfpid_front #(
		.NEURON_COUNT(NEURON_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.err_valid    (err_valid),
		.err_ready    (err_ready),
		.error_sample (error_sample),
		.push_valid   (f_valid),
		.push_ready   (f_ready),
		.push_item    (f_item)
	);

	rbfpid_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_item)
	);

	rbfpid_back #(
		.NEURON_COUNT    (NEURON_COUNT),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (b_valid),
		.in_ready   (b_ready),
		.in_item    (b_item),
		.gain_valid (gain_valid),
		.gain_ready (gain_ready),
		.gain_p     (gain_p),
		.gain_i     (gain_i),
		.gain_d     (gain_d)
	);

	// a normalized mix can never exceed the largest weight
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gain_valid |-> gain_p <= rbfpid_pkg::GAIN_MAX)
		else $error("gain_p above largest weight");

	// every neuron weighs Kp at least as much as Ki and Kd
	a_gain_order: assert property (@(posedge clk) disable iff (!arst_n)
		gain_valid |-> (gain_i <= gain_p) && (gain_d <= gain_p))
		else $error("gain ordering broken");

	// a full queue must hold off the front stage
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready) |=> f_valid)
		else $error("front dropped a request at a full queue");

endmodule

// File: hw/rtl/rbfpid_front.sv
// Front: configuration registers, request accept, distance squares and underflow classing.
module rbfpid_front #(
	parameter int NEURON_COUNT = rbfpid_pkg::NEURON_COUNT_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [rbfpid_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rbfpid_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                      err_valid,
	output logic                                      err_ready,
	input  logic signed [rbfpid_pkg::ERR_W-1:0]       error_sample,
	output logic                                      push_valid,
	input  logic                                      push_ready,
	output rbfpid_pkg::lane_t [NEURON_COUNT-1:0]      push_item
);

	logic signed [rbfpid_pkg::CFG_W-1:0] center_q [rbfpid_pkg::MAX_NEURONS];
	logic [rbfpid_pkg::WID_W-1:0]        width_q  [rbfpid_pkg::MAX_NEURONS];

	logic vld_s1, vld_s2, vld_s3;
	logic en;

	logic [rbfpid_pkg::DIFF_W-1:0] ad_s1 [NEURON_COUNT];
	logic [rbfpid_pkg::WID_W-1:0]  sg_s1 [NEURON_COUNT];
	logic [rbfpid_pkg::D2_W-1:0]   d2_s2 [NEURON_COUNT];
	logic [rbfpid_pkg::S2_W-1:0]   s2_s2 [NEURON_COUNT];
	rbfpid_pkg::lane_t [NEURON_COUNT-1:0] lane_s3;

	assign cfg_ready  = 1'b1;
	assign en         = !vld_s3 || push_ready;
	assign err_ready  = en;
	assign push_valid = vld_s3;
	assign push_item  = lane_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbfpid_pkg::MAX_NEURONS; i++) begin
				center_q[i] <= rbfpid_pkg::CENTER_RST[i];
				width_q[i]  <= rbfpid_pkg::WIDTH_RST[i];
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbfpid_pkg::REG_CENTER_A: center_q[0] <= cfg_data;
				rbfpid_pkg::REG_CENTER_B: center_q[1] <= cfg_data;
				rbfpid_pkg::REG_CENTER_C: center_q[2] <= cfg_data;
				rbfpid_pkg::REG_WIDTH_A:  width_q[0] <= cfg_data[rbfpid_pkg::WID_W-1:0];
				rbfpid_pkg::REG_WIDTH_B:  width_q[1] <= cfg_data[rbfpid_pkg::WID_W-1:0];
				rbfpid_pkg::REG_WIDTH_C:  width_q[2] <= cfg_data[rbfpid_pkg::WID_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= err_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [rbfpid_pkg::DIFF_W-1:0] d;
		if (en) begin
			for (int i = 0; i < NEURON_COUNT; i++) begin
				d = {error_sample[rbfpid_pkg::ERR_W-1], error_sample}
					- {center_q[i][rbfpid_pkg::CFG_W-1], center_q[i]};
				ad_s1[i] <= d[rbfpid_pkg::DIFF_W-1] ? -d : d;
				sg_s1[i] <= (width_q[i] == '0) ? rbfpid_pkg::WID_W'(1) : width_q[i];

				d2_s2[i] <= rbfpid_pkg::D2_W'(ad_s1[i] * ad_s1[i]);
				s2_s2[i] <= rbfpid_pkg::S2_W'(sg_s1[i] * sg_s1[i]);

				lane_s3[i].zero <= {2'b00, d2_s2[i]} >= {s2_s2[i], 5'b00000};
				lane_s3[i].rem  <= rbfpid_pkg::REM_W'(d2_s2[i] >> 5);
				lane_s3[i].low5 <= d2_s2[i][4:0];
				lane_s3[i].s2   <= s2_s2[i];
			end
		end
	end

endmodule

// File: hw/rtl/rbfpid_queue.sv
// Two-entry queue between front and back.
module rbfpid_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] ent0_q, ent1_q;
	logic             vld0_q, vld1_q;
	logic             push, pop;

	assign in_ready  = !vld1_q;
	assign out_valid = vld0_q;
	assign out_data  = ent0_q;
	assign push      = in_valid && in_ready;
	assign pop       = vld0_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld0_q <= 1'b0;
			vld1_q <= 1'b0;
		end else if (pop && vld1_q) begin
			vld1_q <= 1'b0;
		end else if (pop) begin
			vld0_q <= push;
		end else if (push) begin
			if (vld0_q) begin
				vld1_q <= 1'b1;
			end else begin
				vld0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && vld1_q) begin
			ent0_q <= ent1_q;
		end else if (push && (pop || !vld0_q)) begin
			ent0_q <= in_data;
		end else if (push) begin
			ent1_q <= in_data;
		end
	end

endmodule

// File: hw/rtl/rbfpid_back.sv
// Back: exponent division, exp table interpolation, weighting and normalizing division.
module rbfpid_back #(
	parameter int NEURON_COUNT    = rbfpid_pkg::NEURON_COUNT_DEF,
	parameter int EXP_TABLE_DEPTH = rbfpid_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  rbfpid_pkg::lane_t [NEURON_COUNT-1:0] in_item,
	output logic                                 gain_valid,
	input  logic                                 gain_ready,
	output logic [rbfpid_pkg::GAIN_W-1:0]        gain_p,
	output logic [rbfpid_pkg::GAIN_W-1:0]        gain_i,
	output logic [rbfpid_pkg::GAIN_W-1:0]        gain_d
);

	localparam int IW    = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int PW    = rbfpid_pkg::Q_W + IW;
	localparam int DV_N  = rbfpid_pkg::Q_W;
	localparam int RD_N  = rbfpid_pkg::GAIN_W;
	localparam int NSTG  = DV_N + 6 + RD_N;
	localparam int MUL_W = rbfpid_pkg::PHI_W + rbfpid_pkg::FRAC_W;
	localparam int NG    = rbfpid_pkg::GAIN_COUNT;

	// table step 16/depth in Q.32
	localparam logic [63:0] EXP_STEP = (64'd16 << 32) / EXP_TABLE_DEPTH;

	typedef logic [rbfpid_pkg::PHI_W-1:0] rom_t [EXP_TABLE_DEPTH + 1];

	typedef struct packed {
		logic [rbfpid_pkg::REM_W-1:0] rem;
		logic [4:0]                   low5;
		logic [rbfpid_pkg::S2_W-1:0]  s2;
		logic                         zero;
		logic [rbfpid_pkg::Q_W-1:0]   q;
	} dv_t;

	typedef struct packed {
		logic [rbfpid_pkg::TOT_W-1:0]  rem;
		logic [rbfpid_pkg::GAIN_W-1:0] low;
		logic [rbfpid_pkg::GAIN_W-1:0] q;
	} rd_t;

	// elaboration-time floor division by a small count
	function automatic logic [63:0] div_small(logic [63:0] a, logic [5:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[62:0], a[k]};
			if (r >= {58'd0, b}) begin
				r    = r - {58'd0, b};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-x) over [0,16]: Taylor factor in Q.32, repeated product, rounded to Q1.16
	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] s, term, sum, t32;
		s    = EXP_STEP;
		term = 64'd1 << 32;
		sum  = term;
		t32  = term;
		for (int n = 1; n < 40; n++) begin
			if (term != 64'd0) begin
				term = div_small((term * s) >> 32, 6'(n));
				if ((n & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		r[0] = rbfpid_pkg::PHI_W'(65536);
		for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
			t32  = (t32 * sum + (64'd1 << 31)) >> 32;
			r[k] = rbfpid_pkg::PHI_W'((t32 + 64'h8000) >> 16);
		end
		return r;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	function automatic dv_t dv_step(dv_t x);
		dv_t                        y;
		logic [rbfpid_pkg::REM_W:0] t;
		logic                       ge;
		t      = {x.rem, x.low5[4]};
		ge     = t >= {1'b0, x.s2};
		y      = x;
		y.rem  = ge ? rbfpid_pkg::REM_W'(t - {1'b0, x.s2}) : t[rbfpid_pkg::REM_W-1:0];
		y.low5 = {x.low5[3:0], 1'b0};
		y.q    = {x.q[rbfpid_pkg::Q_W-2:0], ge};
		return y;
	endfunction

	function automatic rd_t rd_step(rd_t x, logic [rbfpid_pkg::TOT_W-1:0] dvs);
		rd_t                        y;
		logic [rbfpid_pkg::TOT_W:0] t;
		logic                       ge;
		t     = {x.rem, x.low[rbfpid_pkg::GAIN_W-1]};
		ge    = t >= {1'b0, dvs};
		y.rem = ge ? rbfpid_pkg::TOT_W'(t - {1'b0, dvs}) : t[rbfpid_pkg::TOT_W-1:0];
		y.low = {x.low[rbfpid_pkg::GAIN_W-2:0], 1'b0};
		y.q   = {x.q[rbfpid_pkg::GAIN_W-2:0], ge};
		return y;
	endfunction

	logic [NSTG-1:0] vld_q;
	logic            en;

	dv_t dv_s [DV_N][NEURON_COUNT];

	logic [IW-1:0]                    idx_s1  [NEURON_COUNT];
	logic [rbfpid_pkg::FRAC_W-1:0]    frac_s1 [NEURON_COUNT];
	logic                             zero_s1 [NEURON_COUNT];
	logic [rbfpid_pkg::PHI_W-1:0]     ta_s2   [NEURON_COUNT];
	logic [rbfpid_pkg::PHI_W-1:0]     tb_s2   [NEURON_COUNT];
	logic [rbfpid_pkg::FRAC_W-1:0]    frac_s2 [NEURON_COUNT];
	logic                             zero_s2 [NEURON_COUNT];
	logic [rbfpid_pkg::PHI_W-1:0]     ta_s3   [NEURON_COUNT];
	logic [MUL_W-1:0]                 prod_s3 [NEURON_COUNT];
	logic                             zero_s3 [NEURON_COUNT];
	logic [rbfpid_pkg::PHI_W-1:0]     phi_s4  [NEURON_COUNT];
	logic [rbfpid_pkg::PROD_W-1:0]    pw_s5   [NG][NEURON_COUNT];
	logic [rbfpid_pkg::TOT_W-1:0]     tot_s5;
	logic [rbfpid_pkg::NUM_W-1:0]     nn_s6   [NG];
	logic [rbfpid_pkg::TOT_W-1:0]     tot_s6;
	logic                             tz_s6;

	rd_t                          rd_s   [RD_N][NG];
	logic [rbfpid_pkg::TOT_W-1:0] rtot_s [RD_N];
	logic                         rtz_s  [RD_N];

	assign en         = !vld_q[NSTG-1] || gain_ready;
	assign in_ready   = en;
	assign gain_valid = vld_q[NSTG-1];
	assign gain_p     = rtz_s[RD_N-1] ? '0 : rd_s[RD_N-1][0].q;
	assign gain_i     = rtz_s[RD_N-1] ? '0 : rd_s[RD_N-1][1].q;
	assign gain_d     = rtz_s[RD_N-1] ? '0 : rd_s[RD_N-1][2].q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		dv_t                              d0;
		logic [PW-1:0]                    pos;
		logic [rbfpid_pkg::PHI_W-1:0]     diff;
		logic [rbfpid_pkg::TOT_W-1:0]     tsum;
		logic [rbfpid_pkg::NUM_W-1:0]     nsum;
		rd_t                              r0;
		if (en) begin
			for (int i = 0; i < NEURON_COUNT; i++) begin
				d0.rem  = in_item[i].rem;
				d0.low5 = in_item[i].low5;
				d0.s2   = in_item[i].s2;
				d0.zero = in_item[i].zero;
				d0.q    = '0;
				dv_s[0][i] <= dv_step(d0);
				for (int k = 1; k < DV_N; k++) begin
					dv_s[k][i] <= dv_step(dv_s[k-1][i]);
				end

				pos         = PW'(dv_s[DV_N-1][i].q) * PW'(EXP_TABLE_DEPTH);
				idx_s1[i]  <= pos[PW-1:rbfpid_pkg::FRAC_W];
				frac_s1[i] <= pos[rbfpid_pkg::FRAC_W-1:0];
				zero_s1[i] <= dv_s[DV_N-1][i].zero;

				ta_s2[i]   <= EXP_ROM[idx_s1[i]];
				tb_s2[i]   <= EXP_ROM[idx_s1[i] + IW'(1)];
				frac_s2[i] <= frac_s1[i];
				zero_s2[i] <= zero_s1[i];

				diff        = (ta_s2[i] >= tb_s2[i]) ? ta_s2[i] - tb_s2[i] : '0;
				ta_s3[i]   <= ta_s2[i];
				prod_s3[i] <= MUL_W'(diff * frac_s2[i]);
				zero_s3[i] <= zero_s2[i];

				phi_s4[i] <= zero_s3[i] ? '0
					: ta_s3[i] - prod_s3[i][MUL_W-1:rbfpid_pkg::FRAC_W];

				for (int g = 0; g < NG; g++) begin
					pw_s5[g][i] <= rbfpid_pkg::PROD_W'(phi_s4[i] * rbfpid_pkg::WEIGHTS[i][g]);
				end
			end

			tsum = '0;
			for (int i = 0; i < NEURON_COUNT; i++) begin
				tsum = tsum + rbfpid_pkg::TOT_W'(phi_s4[i]);
			end
			tot_s5 <= tsum;

			for (int g = 0; g < NG; g++) begin
				nsum = rbfpid_pkg::NUM_W'(tot_s5 >> 1);
				for (int i = 0; i < NEURON_COUNT; i++) begin
					nsum = nsum + rbfpid_pkg::NUM_W'(pw_s5[g][i]);
				end
				nn_s6[g] <= nsum;
			end
			tot_s6 <= tot_s5;
			tz_s6  <= (tot_s5 == '0);

			for (int g = 0; g < NG; g++) begin
				r0.rem = nn_s6[g][rbfpid_pkg::NUM_W-1:rbfpid_pkg::GAIN_W];
				r0.low = nn_s6[g][rbfpid_pkg::GAIN_W-1:0];
				r0.q   = '0;
				rd_s[0][g] <= rd_step(r0, tot_s6);
				for (int k = 1; k < RD_N; k++) begin
					rd_s[k][g] <= rd_step(rd_s[k-1][g], rtot_s[k-1]);
				end
			end
			rtot_s[0] <= tot_s6;
			rtz_s[0]  <= tz_s6;
			for (int k = 1; k < RD_N; k++) begin
				rtot_s[k] <= rtot_s[k-1];
				rtz_s[k]  <= rtz_s[k-1];
			end
		end
	end

endmodule
